FILE: rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// shared types, character constants and operator tables for the infix to
// postfix converter
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;  // 'z'
  localparam logic [7:0] CH_OPEN    = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE   = 8'h29;  // ')'
  localparam logic [7:0] CH_PLUS    = 8'h2b;  // '+'
  localparam logic [7:0] CH_MINUS   = 8'h2d;  // '-'
  localparam logic [7:0] CH_STAR    = 8'h2a;  // '*'
  localparam logic [7:0] CH_SLASH   = 8'h2f;  // '/'
  localparam logic [7:0] CH_CARET   = 8'h5e;  // '^'

  // stack entry codes
  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_code_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_OPEN     = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic       last;
    logic [1:0] error;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_sym;
    logic emit_top;
    logic pop;
    logic push_open;
    logic push_op;
    logic set_err;
    err_e err_code;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_letter;
    logic is_open;
    logic is_close;
    logic is_op;
    logic sp_zero;
    logic tos_open;
    logic prec_ge;
    logic err_nz;
    logic fin;
    logic emit_ok;
    logic out_free;
  } status_t;

  function automatic logic [7:0] code_char(op_code_e code);
    logic [7:0] ch;
    case (code)
      OP_ADD:  ch = CH_PLUS;
      OP_SUB:  ch = CH_MINUS;
      OP_MUL:  ch = CH_STAR;
      OP_DIV:  ch = CH_SLASH;
      OP_POW:  ch = CH_CARET;
      default: ch = CH_OPEN;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(op_code_e code);
    logic [1:0] p;
    case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  // operator character to stack code, open code for anything else
  function automatic op_code_e sym_to_code(logic [7:0] ch);
    op_code_e c;
    case (ch)
      CH_PLUS:  c = OP_ADD;
      CH_MINUS: c = OP_SUB;
      CH_STAR:  c = OP_MUL;
      CH_SLASH: c = OP_DIV;
      CH_CARET: c = OP_POW;
      default:  c = OP_OPEN;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of an ASCII infix expression into postfix form
// ----------------------------------------------------------------------------
// usage
//   input channel: one character per transaction (in_data_i.symbol) with
//   end_of_expression marking the last character of an expression
//   output channel: postfix characters; the final transaction of each
//   expression has last set and carries the error code, and is a bare
//   marker (symbol_valid low) when the final step produced no character
// timing
//   a character is taken in one cycle and worked in the next; a letter
//   that is not the final character goes from the symbol register to the
//   output register once the output path has room, which raises out_valid_o
//   operators popped by ')' or by precedence leave one at a time through
//   the pop loop, which also waits for room in the output path
//   the final step then runs S_END, S_FLUSH (one stack entry per step) and
//   S_DONE, or only S_END and S_DONE when a set error drops the stack
// reset
//   empty stack, no error, both channels idle; the stack memory itself is
//   not cleared, only entries below the stack pointer are ever read
// stall
//   the output register holds while out_stall_i is high; the sequencer
//   waits on emission so nothing is dropped, and in_stall_o stays high
//   until the current character is fully worked
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input transactions
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  // output transactions
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// sequencer: accepts one character, steps the pop loops one operator per
// cycle while the output path has room and runs the end-of-expression flush
// ----------------------------------------------------------------------------
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_END   = 5'b00100,
    S_FLUSH = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  state_e step_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign step_done  = status_i.fin ? S_END : S_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (status_i.err_nz) begin
          state_d = step_done;
        end else if (status_i.is_letter) begin
          if (status_i.emit_ok) begin
            cmd_o.emit_sym = 1'b1;
            state_d        = step_done;
          end
        end else if (status_i.is_open) begin
          cmd_o.push_open = 1'b1;
          state_d         = step_done;
        end else if (status_i.is_close) begin
          priority if (status_i.sp_zero) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ERR_CLOSE;
            state_d        = step_done;
          end else if (status_i.tos_open) begin
            cmd_o.pop = 1'b1;
            state_d   = step_done;
          end else if (status_i.emit_ok) begin
            cmd_o.emit_top = 1'b1;
            cmd_o.pop      = 1'b1;
          end
        end else if (status_i.is_op) begin
          if (!status_i.sp_zero && !status_i.tos_open && status_i.prec_ge) begin
            if (status_i.emit_ok) begin
              cmd_o.emit_top = 1'b1;
              cmd_o.pop      = 1'b1;
            end
          end else begin
            cmd_o.push_op = 1'b1;
            state_d       = step_done;
          end
        end else begin
          state_d = step_done;
        end
      end
      S_END: begin
        // an error already raised drops the stack without output
        state_d = status_i.err_nz ? S_DONE : S_FLUSH;
      end
      S_FLUSH: begin
        priority if (status_i.sp_zero) begin
          state_d = S_DONE;
        end else if (status_i.tos_open) begin
          cmd_o.pop = 1'b1;
          if (!status_i.err_nz) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ERR_OPEN;
          end
        end else if (status_i.emit_ok) begin
          cmd_o.emit_top = 1'b1;
          cmd_o.pop      = 1'b1;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/i2p_datapath.sv
// ----------------------------------------------------------------------------
// i2p_datapath
// symbol register, operator stack (top register plus memory), error status,
// one-deep holding register for the final step and the output register
// ----------------------------------------------------------------------------
module i2p_datapath
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output out_t    out_data_o
);

  localparam int unsigned SW          = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW          = $clog2(STACK_DEPTH);
  localparam int unsigned MEM_ENTRIES = 1 << AW;
  localparam logic [SW-1:0] SP_FULL   = SW'(STACK_DEPTH);

  logic [7:0]    sym_q, sym_d;
  logic          fin_q, fin_d;
  logic [SW-1:0] sp_q, sp_d;
  op_code_e      tos_q, tos_d;
  op_code_e      rd_q;
  err_e          err_q, err_d;
  logic          pend_valid_q, pend_valid_d;
  logic [7:0]    pend_sym_q, pend_sym_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  op_code_e      mem [MEM_ENTRIES];

  op_code_e      sym_code, push_code;
  logic          is_letter, is_op, out_free, emit_ok, emit_en, push_en, full;
  logic [7:0]    emit_char;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  assign sym_code  = sym_to_code(sym_q);
  assign is_letter = (sym_q >= CH_LOWER_A) && (sym_q <= CH_LOWER_Z);
  assign is_op     = (sym_q == CH_PLUS) || (sym_q == CH_MINUS) || (sym_q == CH_STAR) ||
                     (sym_q == CH_SLASH) || (sym_q == CH_CARET);
  assign out_free  = !out_valid_q || !out_stall_i;
  // ordinary steps write the output directly, the final step goes through
  // the holding register so that its last result can be tagged
  assign emit_ok   = fin_q ? (!pend_valid_q || out_free) : out_free;
  assign emit_en   = cmd_i.emit_sym || cmd_i.emit_top;
  assign emit_char = cmd_i.emit_sym ? sym_q : code_char(tos_q);
  assign push_en   = cmd_i.push_open || cmd_i.push_op;
  assign push_code = cmd_i.push_open ? OP_OPEN : sym_code;
  assign full      = (sp_q == SP_FULL);

  assign status_o.is_letter = is_letter;
  assign status_o.is_open   = (sym_q == CH_OPEN);
  assign status_o.is_close  = (sym_q == CH_CLOSE);
  assign status_o.is_op     = is_op;
  assign status_o.sp_zero   = (sp_q == '0);
  assign status_o.tos_open  = (tos_q == OP_OPEN);
  assign status_o.prec_ge   = (code_prec(tos_q) >= code_prec(sym_code));
  assign status_o.err_nz    = (err_q != ERR_NONE);
  assign status_o.fin       = fin_q;
  assign status_o.emit_ok   = emit_ok;
  assign status_o.out_free  = out_free;

  always_comb begin
    sym_d        = sym_q;
    fin_d        = fin_q;
    sp_d         = sp_q;
    tos_d        = tos_q;
    err_d        = err_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      sym_d = in_data_i.symbol;
      fin_d = in_data_i.end_of_expression;
    end
    if (cmd_i.pop) begin
      sp_d  = sp_q - SW'(1);
      tos_d = rd_q;
    end
    if (push_en) begin
      if (full) begin
        err_d = ERR_OVERFLOW;
      end else begin
        tos_d = push_code;
        sp_d  = sp_q + SW'(1);
      end
    end
    if (cmd_i.set_err) begin
      err_d = cmd_i.err_code;
    end
    if (emit_en) begin
      if (!fin_q) begin
        out_d       = '{out_symbol: emit_char, symbol_valid: 1'b1, last: 1'b0, error: 2'b00};
        out_valid_d = 1'b1;
      end else begin
        if (pend_valid_q) begin
          out_d       = '{out_symbol: pend_sym_q, symbol_valid: 1'b1, last: 1'b0,
                          error: 2'b00};
          out_valid_d = 1'b1;
        end
        pend_sym_d   = emit_char;
        pend_valid_d = 1'b1;
      end
    end
    if (cmd_i.finish) begin
      if (pend_valid_q) begin
        out_d = '{out_symbol: pend_sym_q, symbol_valid: 1'b1, last: 1'b1, error: err_q};
      end else begin
        out_d = '{out_symbol: 8'h00, symbol_valid: 1'b0, last: 1'b1, error: err_q};
      end
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
      sp_d         = '0;
      err_d        = ERR_NONE;
    end
  end

  // entries below the top live in memory; rd_q tracks the entry under the top
  assign mem_we    = push_en && !full && (sp_q != '0);
  assign mem_waddr = AW'(sp_q - SW'(1));
  assign mem_raddr = AW'(sp_d - SW'(2));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos_q;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rd_q <= tos_q;
    end else begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q        <= 1'b0;
      sp_q         <= '0;
      err_q        <= ERR_NONE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fin_q        <= fin_d;
      sp_q         <= sp_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    tos_q      <= tos_d;
    pend_sym_q <= pend_sym_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_FULL)
    else $error("stack pointer beyond depth");

  a_pend_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> fin_q)
    else $error("holding register used outside the final step");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (sp_q != '0))
    else $error("pop from empty stack");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |-> emit_ok)
    else $error("emit without room in output path");

  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> out_free)
    else $error("finish while output register is held");

endmodule
